// ----- rtl/bdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, request and status codes, FSM and interface types for the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Store depth and derived widths
  localparam int DEPTH   = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W  = 32;
  localparam int REQ_W   = 3;
  localparam int ST_W    = 3;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes (unused codes act as pop right)
  localparam logic [REQ_W-1:0] REQ_PUSH_L = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_R = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_L  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_R  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [ST_W-1:0] ST_POPPED  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_LOAD
  } ctl_state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/bdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: takes a request beat, runs one execute step, then hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire bdq_pkg::dp_sts_t sts,
  output bdq_pkg::dp_cmd_t      cmd
);
  import bdq_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_tvalid) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        state_nxt = CS_LOAD;
      end
      CS_LOAD: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.latch_in = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
      end
      CS_EXEC: begin
        cmd.exec = 1'b1;
      end
      CS_LOAD: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/bdq_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: circular word store, head pointer, count, capacity register and
// the output register with its valid flag.
// ----------------------------------------------------------------------------
module bdq_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bdq_pkg::dp_cmd_t            cmd,
  output bdq_pkg::dp_sts_t                 sts,
  input  wire logic [bdq_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [bdq_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [bdq_pkg::OUT_W-1:0]        out_tdata
);
  import bdq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [REQ_W-1:0]  req_r;
  logic [WORD_W-1:0] val_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  capacity_r;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [WORD_W-1:0] rd_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [CMP_W-1:0]  limit;
  logic [PTR_W-1:0]  head_dec, head_inc, tail_pos, last_pos;
  logic [SUM_W-1:0]  tail_sum, last_sum;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic              wr_en;
  logic              is_push, full, empty;
  logic [WORD_W-1:0] data_sel;
  logic [CMP_W-1:0]  occ_wide;

  // Effective limit saturates at the store depth
  assign limit = (CMP_W'(capacity_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity_r);

  assign head_dec = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // head + count and head + count - 1, folded once (both stay below 2*DEPTH while count is nonzero)
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign last_sum = tail_sum - 1'b1;
  assign tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                : PTR_W'(tail_sum);
  assign last_pos = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                                : PTR_W'(last_sum);

  assign is_push = (req_r == REQ_PUSH_L) || (req_r == REQ_PUSH_R);
  assign full    = (CMP_W'(count_r) >= limit);
  assign empty   = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_CLEARED;
    wr_en      = 1'b0;
    wr_addr    = tail_pos;
    rd_addr    = last_pos;
    if (req_r == REQ_CLEAR) begin
      head_nxt   = '0;
      count_nxt  = '0;
      status_nxt = ST_CLEARED;
    end else if (is_push) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        wr_en      = 1'b1;
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_PUSHED;
        if (req_r == REQ_PUSH_L) begin
          head_nxt = head_dec;
          wr_addr  = head_dec;
        end
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_POPPED;
        if (req_r == REQ_POP_L) begin
          rd_addr  = head_r;
          head_nxt = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) capacity_r <= cfg_wdata;
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_tdata[REQ_W-1:0];
      val_r <= in_tdata[REQ_W+WORD_W-1:REQ_W];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_r     <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= val_r;
    end
    if (cmd.load_out) out_data_r <= {occ_wide[OCC_W-1:0], data_sel, status_r};
  end

  always_comb begin
    case (status_r)
      ST_PUSHED: data_sel = val_r;
      ST_POPPED: data_sel = rd_r;
      default:   data_sel = '0;
    endcase
  end

  assign occ_wide     = CMP_W'(count_r);
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  // Occupancy never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("count beyond depth");

  // A refused push leaves the queue alone
  a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt == ST_FULL) |=> ($stable(count_r) && $stable(head_r)))
    else $error("full push changed the queue");

  // A successful pop removes exactly one word
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt == ST_POPPED) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not decrement count");

  // Result register is never overwritten while a result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- rtl/bounded_double_ended_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Bounded deque of signed 32-bit words in a circular store.
//
// Usage:
//   in_*  : request beats. tdata = {pad, push_value[31:0], req_type[2:0]}.
//           req_type 0/1 push left/right, 2/3 pop left/right, 4 clear.
//   out_* : one result beat per request. tdata = {occupancy[4:0],
//           data_out[31:0], status[2:0]}; status 0 pushed, 1 popped,
//           2 full, 3 empty, 4 cleared.
//   cfg_* : cfg_we writes cfg_wdata into the capacity register (reset 16,
//           limited to the store depth). Write only while idle.
// Timing: a request is taken in the idle state, executed in the execute state
//   (store access, pointer and count update) and then loaded into the output
//   register once that register is free. The sequencer handles one request
//   at a time and takes no new request until the last result is loaded.
//   The store read port is registered, which sets the execute-to-result step.
// Reset (rst_n low, synchronous): queue empty, head at 0, capacity 16, no
//   result pending. The store itself is not cleared.
// Stall: while out_tready is low the result holds; one further request may
//   be taken and executed, then waits until the output register frees.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [bdq_pkg::IN_W-1:0]   in_tdata,   // req_type[2:0], push_value[34:3], 0
  // result channel
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [bdq_pkg::OUT_W-1:0]       out_tdata,  // status[2:0], data_out[34:3], occupancy[39:35]
  // capacity register
  input  wire logic                       cfg_we,
  input  wire logic [bdq_pkg::CAP_W-1:0]  cfg_wdata
);
  import bdq_pkg::*;

  dp_cmd_t cmd;   // sequencer -> datapath strobes
  dp_sts_t sts;   // datapath -> sequencer status

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded double-ended queue. A shadow deque
// predicts status, word and occupancy for every accepted request beat; each
// result beat is checked against the oldest prediction. A short directed
// part covers empty and full ends, word extremes, clear and the spare request
// codes. Random phases follow at a range of capacities, with bursty idling on
// both sides and one long result stall that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import bdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 300;
  localparam int SETTLE      = 8;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] data;
    logic [OCC_W-1:0]  occ;
  } deque_result_t;

  // Shadow copy of the deque; predicts one result per request beat
  class deque_shadow;
    logic [WORD_W-1:0] words [DEPTH];
    int unsigned       head;
    int unsigned       count;
    logic [CAP_W-1:0]  capacity;
    deque_result_t     awaited_results [$];
    int                errors;

    function new();
      foreach (words[i]) words[i] = '0;
      head     = 0;
      count    = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void take_request(logic [REQ_W-1:0] req, logic [WORD_W-1:0] val);
      deque_result_t r;
      int unsigned   limit;
      limit  = (capacity > DEPTH) ? DEPTH : capacity;
      r.data = '0;
      case (req)
        REQ_CLEAR: begin
          head     = 0;
          count    = 0;
          r.status = ST_CLEARED;
        end
        REQ_PUSH_L, REQ_PUSH_R: begin
          if (count >= limit) begin
            r.status = ST_FULL;
          end else begin
            if (req == REQ_PUSH_L) begin
              head        = (head + DEPTH - 1) % DEPTH;
              words[head] = val;
            end else begin
              words[(head + count) % DEPTH] = val;
            end
            count++;
            r.data   = val;
            r.status = ST_PUSHED;
          end
        end
        default: begin
          // pop left, pop right and the spare codes (which pop right)
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (req == REQ_POP_L) begin
              r.data = words[head];
              head   = (head + 1) % DEPTH;
            end else begin
              r.data = words[(head + count - 1) % DEPTH];
            end
            count--;
            r.status = ST_POPPED;
          end
        end
      endcase
      r.occ = count[OCC_W-1:0];
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] beat);
      deque_result_t exp_r;
      logic [ST_W-1:0]   got_st;
      logic [WORD_W-1:0] got_data;
      logic [OCC_W-1:0]  got_occ;
      got_st   = beat[ST_W-1:0];
      got_data = beat[ST_W +: WORD_W];
      got_occ  = beat[ST_W+WORD_W +: OCC_W];
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", beat));
      end else begin
        exp_r = awaited_results[0];
        awaited_results.delete(0);
        if (got_st !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", got_st, exp_r.status));
        if (got_data !== exp_r.data)
          report_mismatch($sformatf("word %h, expected %h", got_data, exp_r.data));
        if (got_occ !== exp_r.occ)
          report_mismatch($sformatf("occupancy %0d, expected %0d", got_occ, exp_r.occ));
      end
    endtask

    task check_drained();
      if (awaited_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;   // req_type[2:0], push_value[34:3], zero pad
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;  // status[2:0], data_out[34:3], occupancy[39:35]
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;

  deque_shadow shadow = new();

  int idle_pct   = 0;   // chance per beat / per cycle of an idle burst
  bit long_stall = 1'b0; // set by stimulus, served and cleared by receiver
  int cycle_cnt  = 0;

  bounded_double_ended_queue_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata);
  end

  // Result side: random back-pressure bursts, plus the one long stall that
  // lets the block fill and drop in_tready while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (long_stall) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        long_stall = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called and returns at a falling edge; in_tvalid is left high so the
  // next beat can follow without a bubble.
  task send_request(logic [REQ_W-1:0] req, logic [WORD_W-1:0] val);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-REQ_W-WORD_W){1'b0}}, val, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_request(req, val);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task settle_queue();
    in_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Capacity only changes while the block is idle
  task write_capacity(logic [CAP_W-1:0] v);
    settle_queue();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    shadow.set_capacity(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Extremes turn up often so sign and top bits get exercised
  function logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function logic [REQ_W-1:0] pick_request(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return REQ_CLEAR;
    else if (r < 6)
      return REQ_W'($urandom_range(5, 7));   // spare codes, act as pop right
    else if (r < 6 + push_pct * 94 / 100)
      return $urandom_range(0, 1) ? REQ_PUSH_L : REQ_PUSH_R;
    else
      return $urandom_range(0, 1) ? REQ_POP_L : REQ_POP_R;
  endfunction

  // One random phase; the queue is not cleared on entry, so a lower
  // capacity can land below the current occupancy.
  task run_phase(logic [CAP_W-1:0] cap, int n_beats, int push_pct, int idle);
    write_capacity(cap);
    idle_pct = idle;
    repeat (n_beats) send_request(pick_request(push_pct), pick_word());
  endtask

  initial begin
    int p;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: capacity 2, both ends empty and full, extremes, spare codes
    idle_pct = 0;
    write_capacity(5'd2);
    send_request(REQ_POP_L,  32'h1234_5678);  // empty
    send_request(REQ_POP_R,  32'h0);          // empty
    send_request(3'd5,       32'h0);          // spare code on empty
    send_request(REQ_PUSH_L, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_R, 32'h8000_0000);
    send_request(REQ_PUSH_L, 32'h0000_0000);  // full
    send_request(REQ_PUSH_R, 32'hFFFF_FFFF);  // full
    send_request(3'd6,       32'h0);          // pops right
    send_request(REQ_POP_L,  32'h0);
    send_request(REQ_POP_L,  32'h0);          // empty again
    send_request(REQ_PUSH_R, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_L, 32'h0000_0001);
    send_request(REQ_CLEAR,  32'hDEAD_BEEF);
    send_request(3'd7,       32'h0);          // cleared queue is empty
    send_request(REQ_PUSH_R, 32'h5A5A_5A5A);
    send_request(REQ_POP_R,  32'h0);

    // Directed: capacity zero, every push is refused
    write_capacity(5'd0);
    send_request(REQ_PUSH_L, 32'h8000_0000);
    send_request(REQ_PUSH_R, 32'h7FFF_FFFF);
    send_request(REQ_POP_R,  32'h0);
    send_request(REQ_CLEAR,  32'h0);

    // Capacity above depth saturates; the long stall falls in this phase.
    // Drain first so the stall overlaps beats being offered, not the settle.
    write_capacity(5'd31);
    long_stall = 1'b1;
    run_phase(5'd31, 150, 80, 10);
    // Capacity dropped under the occupancy left behind: pushes refused until pops bring it down
    run_phase(5'd4,  120, 50, 25);
    run_phase(5'd16, 150, 50, 0);
    run_phase(5'd1,   80, 50, 30);
    run_phase(5'd17, 120, 65, 15);
    repeat (3) begin
      p = $urandom_range(30, 70);
      run_phase(CAP_W'($urandom_range(0, 31)), 100, p, $urandom_range(0, 30));
    end
    run_phase(5'd16,  80, 20, 20);
    // Closing stretch at full rate on both sides
    run_phase(5'd15, 150, 55, 0);

    settle_queue();
    repeat (20) @(negedge clk);
    shadow.check_drained();
    if (shadow.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
